@@ rtl/core/vsaq_pkg.sv @@
package vsaq_pkg;

	// number of qualified conditions: low rate, high rate, low oxygen
	localparam int unsigned COND_COUNT = 3;

	// field widths
	localparam int unsigned RATE_W = 8;
	localparam int unsigned OXY_W  = 7;
	localparam int unsigned TIME_W = 32;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_RATE_LOW  = 3'd0;
	localparam cfg_idx_t CFG_RATE_HIGH = 3'd1;
	localparam cfg_idx_t CFG_OXY_LOW   = 3'd2;
	localparam cfg_idx_t CFG_CONFIRM   = 3'd3;
	localparam cfg_idx_t CFG_CLEAR     = 3'd4;

	// register reset values
	localparam logic [RATE_W-1:0] RATE_LOW_RST  = 8'd50;
	localparam logic [RATE_W-1:0] RATE_HIGH_RST = 8'd120;
	localparam logic [OXY_W-1:0]  OXY_LOW_RST   = 7'd90;
	localparam logic [TIME_W-1:0] CONFIRM_RST   = 32'd5000;
	localparam logic [TIME_W-1:0] CLEAR_RST     = 32'd5000;

	// condition slots
	localparam int unsigned COND_RATE_LOW  = 0;
	localparam int unsigned COND_RATE_HIGH = 1;
	localparam int unsigned COND_OXY_LOW   = 2;

	typedef logic [COND_COUNT-1:0] cond_vec_t;

endpackage

@@ rtl/core/vsaq_chan_if.sv @@
// measurement channel
interface vsaq_meas_if;
	import vsaq_pkg::*;

	logic              valid;
	logic              ready;
	logic              is_measuring;
	logic              signal_ok;
	logic              rate_ok;
	logic              oxygen_ok;
	logic [RATE_W-1:0] heart_rate;
	logic [OXY_W-1:0]  oxygen_level;
	logic [TIME_W-1:0] time_ms;

	modport source (
		output valid, is_measuring, signal_ok, rate_ok, oxygen_ok,
		       heart_rate, oxygen_level, time_ms,
		input  ready
	);
	modport sink (
		input  valid, is_measuring, signal_ok, rate_ok, oxygen_ok,
		       heart_rate, oxygen_level, time_ms,
		output ready
	);
endinterface

// alert result channel
interface vsaq_alert_if;
	logic valid;
	logic ready;
	logic rate_low_alert;
	logic rate_high_alert;
	logic oxygen_low_alert;
	logic any_alert;

	modport source (
		output valid, rate_low_alert, rate_high_alert, oxygen_low_alert, any_alert,
		input  ready
	);
	modport sink (
		input  valid, rate_low_alert, rate_high_alert, oxygen_low_alert, any_alert,
		output ready
	);
endinterface

@@ rtl/core/vital_sign_alert_qualifier_core.sv @@
// Time-qualified threshold alarm for heart rate and oxygen saturation.
// meas: one timestamped measurement per transaction (valid/ready).
// alert: one result per measurement with the three confirmed alert flags
//   and their OR, in input order.
// cfg: write-only register port; cfg_we high at a clock edge writes
//   cfg_data into register cfg_index (0 rate low, 1 rate high, 2 oxygen low,
//   3 confirm time, 4 clear time); other indexes are ignored. Write only
//   while no measurement is in flight.
// Pipeline: two register stages (input register, then the condition cells
//   feeding the result register).
// Throughput: one measurement per cycle while alert.ready does not stall;
//   the three condition cells each do one 32-bit subtract and compare per cycle.
// Stall: when alert.ready is low the result register holds, the input
//   register takes one more measurement if it is empty, then meas.ready drops.
// Reset (arst_n low): registers return to defaults, condition history
//   clears, both pipeline stages empty; the alert flags are not reset.
module vital_sign_alert_qualifier_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  vsaq_pkg::cfg_idx_t          cfg_index,
	input  logic [vsaq_pkg::CFG_DATA_W-1:0] cfg_data,
	vsaq_meas_if.sink                   meas,
	vsaq_alert_if.source                alert
);
	import vsaq_pkg::*;

	// configuration registers
	logic [RATE_W-1:0] rate_low_limit_q;
	logic [RATE_W-1:0] rate_high_limit_q;
	logic [OXY_W-1:0]  oxygen_low_limit_q;
	logic [TIME_W-1:0] confirm_time_q;
	logic [TIME_W-1:0] clear_time_q;

	// input stage
	logic              valid_s1;
	logic              rate_valid_s1;
	logic              oxy_valid_s1;
	logic [RATE_W-1:0] heart_rate_s1;
	logic [OXY_W-1:0]  oxygen_level_s1;
	logic [TIME_W-1:0] time_s1;

	// result stage
	logic      valid_s2;
	cond_vec_t alert_s2;

	// condition history
	cond_vec_t         raw_q;
	cond_vec_t         active_q;
	logic [TIME_W-1:0] change_time_q [COND_COUNT];

	logic              s2_free;
	logic              advance;
	cond_vec_t         raw_now;
	cond_vec_t         active_next;
	logic [TIME_W-1:0] change_next [COND_COUNT];
	logic [TIME_W-1:0] elapsed [COND_COUNT];

	// handshake control
	assign s2_free    = !valid_s2 || alert.ready;
	assign advance    = valid_s1 && s2_free;
	assign meas.ready = !valid_s1 || s2_free;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_low_limit_q   <= RATE_LOW_RST;
			rate_high_limit_q  <= RATE_HIGH_RST;
			oxygen_low_limit_q <= OXY_LOW_RST;
			confirm_time_q     <= CONFIRM_RST;
			clear_time_q       <= CLEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RATE_LOW:  rate_low_limit_q   <= cfg_data[RATE_W-1:0];
				CFG_RATE_HIGH: rate_high_limit_q  <= cfg_data[RATE_W-1:0];
				CFG_OXY_LOW:   oxygen_low_limit_q <= cfg_data[OXY_W-1:0];
				CFG_CONFIRM:   confirm_time_q     <= cfg_data[TIME_W-1:0];
				CFG_CLEAR:     clear_time_q       <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: validity folded into two qualifiers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas.ready) begin
			valid_s1 <= meas.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meas.ready && meas.valid) begin
			rate_valid_s1   <= meas.is_measuring && meas.signal_ok && meas.rate_ok;
			oxy_valid_s1    <= meas.is_measuring && meas.signal_ok && meas.oxygen_ok;
			heart_rate_s1   <= meas.heart_rate;
			oxygen_level_s1 <= meas.oxygen_level;
			time_s1         <= meas.time_ms;
		end
	end

	// raw threshold conditions
	always_comb begin
		raw_now[COND_RATE_LOW]  = rate_valid_s1 && (heart_rate_s1 < rate_low_limit_q);
		raw_now[COND_RATE_HIGH] = rate_valid_s1 && (heart_rate_s1 > rate_high_limit_q);
		raw_now[COND_OXY_LOW]   = oxy_valid_s1 && (oxygen_level_s1 < oxygen_low_limit_q);
	end

	// qualification cells, one per condition
	always_comb begin
		for (int k = 0; k < COND_COUNT; k++) begin
			change_next[k] = (raw_now[k] != raw_q[k]) ? time_s1 : change_time_q[k];
			elapsed[k]     = time_s1 - change_next[k];
			if (active_q[k]) begin
				active_next[k] = !(!raw_now[k] && (elapsed[k] >= clear_time_q));
			end else begin
				active_next[k] = raw_now[k] && (elapsed[k] >= confirm_time_q);
			end
		end
	end

	// history update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q    <= '0;
			active_q <= '0;
			for (int k = 0; k < COND_COUNT; k++) begin
				change_time_q[k] <= '0;
			end
		end else if (advance) begin
			raw_q    <= raw_now;
			active_q <= active_next;
			for (int k = 0; k < COND_COUNT; k++) begin
				change_time_q[k] <= change_next[k];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			alert_s2 <= active_next;
		end
	end

	assign alert.valid            = valid_s2;
	assign alert.rate_low_alert   = alert_s2[COND_RATE_LOW];
	assign alert.rate_high_alert  = alert_s2[COND_RATE_HIGH];
	assign alert.oxygen_low_alert = alert_s2[COND_OXY_LOW];
	assign alert.any_alert        = |alert_s2;

endmodule

@@ rtl/core/vsaq_checker.sv @@
module vsaq_checker (
	input logic clk,
	input logic arst_n,
	input logic meas_valid,
	input logic meas_ready,
	input logic alert_valid,
	input logic alert_ready,
	input logic rate_low_alert,
	input logic rate_high_alert,
	input logic oxygen_low_alert,
	input logic any_alert
);
	logic       meas_take;
	logic       alert_take;
	logic [1:0] pending_q;

	assign meas_take  = meas_valid && meas_ready;
	assign alert_take = alert_valid && alert_ready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, meas_take} - {1'b0, alert_take};
		end
	end

	// at most two measurements in flight
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more measurements in flight than pipeline stages");

	// no result without an accepted measurement
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid |-> pending_q != 2'd0)
		else $error("result shown with no measurement pending");

	// summary flag tracks the three alerts
	a_any_alert: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid |-> any_alert == (rate_low_alert || rate_high_alert || oxygen_low_alert))
		else $error("any_alert disagrees with individual alerts");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid && !alert_ready |=> alert_valid
			&& $stable(rate_low_alert) && $stable(rate_high_alert)
			&& $stable(oxygen_low_alert))
		else $error("result changed while stalled");

endmodule

bind vital_sign_alert_qualifier_core vsaq_checker u_vsaq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.meas_valid       (meas.valid),
	.meas_ready       (meas.ready),
	.alert_valid      (alert.valid),
	.alert_ready      (alert.ready),
	.rate_low_alert   (alert.rate_low_alert),
	.rate_high_alert  (alert.rate_high_alert),
	.oxygen_low_alert (alert.oxygen_low_alert),
	.any_alert        (alert.any_alert)
);

@@ tb/vsaq_alert_compare.sv @@
`timescale 1ns / 1ps

// watches both channels and the register port, predicts the alert flags of
// every accepted measurement and compares them with the result stream
module vsaq_alert_compare (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  vsaq_pkg::cfg_idx_t              cfg_index,
	input  logic [vsaq_pkg::CFG_DATA_W-1:0] cfg_data,
	vsaq_meas_if                            meas,
	vsaq_alert_if                           alert,
	output int unsigned                     fail_count,
	output int unsigned                     pending,
	output int unsigned                     checked,
	output int unsigned                     raised
);
	import vsaq_pkg::*;

	typedef struct packed {
		logic rate_low;
		logic rate_high;
		logic oxy_low;
		logic any;
	} alert_flags_t;

	// shadow of the register file
	logic [RATE_W-1:0] lim_rate_low;
	logic [RATE_W-1:0] lim_rate_high;
	logic [OXY_W-1:0]  lim_oxy_low;
	logic [TIME_W-1:0] hold_on_ms;
	logic [TIME_W-1:0] hold_off_ms;

	// per-condition history
	cond_vec_t         raw_q;
	cond_vec_t         active_q;
	logic [TIME_W-1:0] changed_at [COND_COUNT];

	alert_flags_t expected_alerts [$];

	// one measurement through the three qualification cells
	function automatic alert_flags_t qualify(
		input logic              measuring,
		input logic              sig_ok,
		input logic              hr_ok,
		input logic              ox_ok,
		input logic [RATE_W-1:0] hr,
		input logic [OXY_W-1:0]  ox,
		input logic [TIME_W-1:0] now
	);
		cond_vec_t         raw_now;
		logic [TIME_W-1:0] elapsed;
		alert_flags_t      flags;
		raw_now[COND_RATE_LOW]  = measuring && sig_ok && hr_ok && (hr < lim_rate_low);
		raw_now[COND_RATE_HIGH] = measuring && sig_ok && hr_ok && (hr > lim_rate_high);
		raw_now[COND_OXY_LOW]   = measuring && sig_ok && ox_ok && (ox < lim_oxy_low);
		for (int k = 0; k < COND_COUNT; k++) begin
			if (raw_now[k] != raw_q[k]) begin
				raw_q[k]      = raw_now[k];
				changed_at[k] = now;
			end
			// modulo 2^32 elapsed time
			elapsed = now - changed_at[k];
			if (active_q[k]) begin
				if (!raw_q[k] && elapsed >= hold_off_ms)
					active_q[k] = 1'b0;
			end else if (raw_q[k] && elapsed >= hold_on_ms) begin
				active_q[k] = 1'b1;
			end
		end
		flags.rate_low  = active_q[COND_RATE_LOW];
		flags.rate_high = active_q[COND_RATE_HIGH];
		flags.oxy_low   = active_q[COND_OXY_LOW];
		flags.any       = |active_q;
		return flags;
	endfunction

	function automatic bit field_ok(input string name, input logic want, input logic got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %b, got %b", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alert_flags_t want;
		alert_flags_t got;
		logic         bad;
		if (!arst_n) begin
			lim_rate_low  = RATE_LOW_RST;
			lim_rate_high = RATE_HIGH_RST;
			lim_oxy_low   = OXY_LOW_RST;
			hold_on_ms    = CONFIRM_RST;
			hold_off_ms   = CLEAR_RST;
			raw_q         = '0;
			active_q      = '0;
			for (int k = 0; k < COND_COUNT; k++)
				changed_at[k] = '0;
			expected_alerts.delete();
			fail_count = 0;
			pending    = 0;
			checked    = 0;
			raised     = 0;
		end else begin
			// register writes happen only while the pipeline is empty
			if (cfg_we) begin
				case (cfg_index)
					CFG_RATE_LOW:  lim_rate_low  = cfg_data[RATE_W-1:0];
					CFG_RATE_HIGH: lim_rate_high = cfg_data[RATE_W-1:0];
					CFG_OXY_LOW:   lim_oxy_low   = cfg_data[OXY_W-1:0];
					CFG_CONFIRM:   hold_on_ms    = cfg_data[TIME_W-1:0];
					CFG_CLEAR:     hold_off_ms   = cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end

			// result transaction against the oldest prediction
			if (alert.valid && alert.ready) begin
				got = {alert.rate_low_alert, alert.rate_high_alert,
				       alert.oxygen_low_alert, alert.any_alert};
				if (expected_alerts.size() == 0) begin
					$display("%0t: unexpected alert transaction, expected none, got %b",
					         $time, got);
					fail_count++;
				end else begin
					want = expected_alerts.pop_front();
					bad  = 1'b0;
					if (!field_ok("rate_low_alert", want.rate_low, got.rate_low))
						bad = 1'b1;
					if (!field_ok("rate_high_alert", want.rate_high, got.rate_high))
						bad = 1'b1;
					if (!field_ok("oxygen_low_alert", want.oxy_low, got.oxy_low))
						bad = 1'b1;
					if (!field_ok("any_alert", want.any, got.any))
						bad = 1'b1;
					if (bad)
						fail_count++;
					checked++;
					if (want.any)
						raised++;
				end
			end

			// measurement transaction: predict its result
			if (meas.valid && meas.ready)
				expected_alerts.push_back(qualify(meas.is_measuring, meas.signal_ok,
					meas.rate_ok, meas.oxygen_ok, meas.heart_rate, meas.oxygen_level,
					meas.time_ms));
			pending = expected_alerts.size();
		end
	end

endmodule

@@ tb/tb_vital_sign_alert_qualifier_core.sv @@
`timescale 1ns / 1ps

module tb_vital_sign_alert_qualifier_core;
	import vsaq_pkg::*;

	// sensor flag order: is_measuring, signal_ok, rate_ok, oxygen_ok
	localparam logic [3:0] SENSOR_ALL_OK = 4'b1111;
	localparam logic [3:0] SENSOR_IDLE   = 4'b0111;
	localparam logic [3:0] SIGNAL_BAD    = 4'b1011;
	localparam logic [3:0] RATE_BAD      = 4'b1101;
	localparam logic [3:0] OXYGEN_BAD    = 4'b1110;

	typedef enum int unsigned {BAND_NORMAL, BAND_LOW, BAND_HIGH} rate_band_t;
	typedef enum int unsigned {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_EVERY_FIFTH}
		stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	vsaq_meas_if  meas_ch ();
	vsaq_alert_if alert_ch ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;
	int unsigned raised;

	// current register values, used to aim the stimulus at the thresholds
	logic [RATE_W-1:0] set_rate_low  = RATE_LOW_RST;
	logic [RATE_W-1:0] set_rate_high = RATE_HIGH_RST;
	logic [OXY_W-1:0]  set_oxy_low   = OXY_LOW_RST;
	logic [TIME_W-1:0] now_ms        = '0;
	int unsigned       burst_left    = 0;
	int unsigned       settings_used = 0;

	vital_sign_alert_qualifier_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.meas      (meas_ch),
		.alert     (alert_ch)
	);

	vsaq_alert_compare alert_compare (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.meas       (meas_ch),
		.alert      (alert_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.raised     (raised)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side backpressure, switching between stall patterns
	initial begin : alert_backpressure
		stall_mode_t mode;
		int unsigned span;
		alert_ch.ready = 1'b1;
		@(posedge arst_n);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(8, 64);
			for (int tick = 0; tick < span; tick++) begin
				@(negedge clk);
				case (mode)
					READY_ALWAYS:      alert_ch.ready <= 1'b1;
					READY_COIN:        alert_ch.ready <= 1'($urandom);
					READY_SPARSE:      alert_ch.ready <= ($urandom_range(0, 3) == 0);
					READY_EVERY_FIFTH: alert_ch.ready <= (tick % 5 == 0);
					default:           alert_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// one measurement transaction, with burst and gap shaping
	task automatic measure(
		input logic [3:0]        flags,
		input logic [RATE_W-1:0] hr,
		input logic [OXY_W-1:0]  ox,
		input logic [TIME_W-1:0] t
	);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				meas_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		meas_ch.valid        <= 1'b1;
		meas_ch.is_measuring <= flags[3];
		meas_ch.signal_ok    <= flags[2];
		meas_ch.rate_ok      <= flags[1];
		meas_ch.oxygen_ok    <= flags[0];
		meas_ch.heart_rate   <= hr;
		meas_ch.oxygen_level <= ox;
		meas_ch.time_ms      <= t;
		do
			@(posedge clk);
		while (!meas_ch.ready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop sending and wait for every predicted result to come back
	task automatic drain();
		@(negedge clk);
		meas_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic apply_setting(
		input logic [RATE_W-1:0] lo,
		input logic [RATE_W-1:0] hi,
		input logic [OXY_W-1:0]  oxy,
		input logic [TIME_W-1:0] on_ms,
		input logic [TIME_W-1:0] off_ms
	);
		drain();
		write_reg(CFG_RATE_LOW, CFG_DATA_W'(lo));
		write_reg(CFG_RATE_HIGH, CFG_DATA_W'(hi));
		write_reg(CFG_OXY_LOW, CFG_DATA_W'(oxy));
		write_reg(CFG_CONFIRM, on_ms);
		write_reg(CFG_CLEAR, off_ms);
		// indexes past the last register must be ignored
		for (int i = CFG_CLEAR + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(cfg_idx_t'(i), $urandom());
		set_rate_low  = lo;
		set_rate_high = hi;
		set_oxy_low   = oxy;
		settings_used++;
	endtask

	function automatic logic [RATE_W-1:0] pick_rate(input rate_band_t band);
		case (band)
			BAND_LOW:
				if (set_rate_low != 0)
					return RATE_W'($urandom_range(0, int'(set_rate_low) - 1));
			BAND_HIGH:
				if (set_rate_high != '1)
					return RATE_W'($urandom_range(int'(set_rate_high) + 1, 255));
			default:
				if (set_rate_low <= set_rate_high)
					return RATE_W'($urandom_range(int'(set_rate_low), int'(set_rate_high)));
		endcase
		return RATE_W'($urandom);
	endfunction

	function automatic logic [OXY_W-1:0] pick_oxygen(input logic want_low);
		if (want_low) begin
			if (set_oxy_low != 0)
				return OXY_W'($urandom_range(0, int'(set_oxy_low) - 1));
			return OXY_W'($urandom);
		end
		// mostly in the nominal range, now and then past 100 percent
		if (set_oxy_low <= 100 && $urandom_range(0, 7) != 0)
			return OXY_W'($urandom_range(int'(set_oxy_low), 100));
		return OXY_W'($urandom_range(int'(set_oxy_low), 127));
	endfunction

	// episodes of steady vital signs with advancing time, plus random noise
	task automatic run_traffic(input int unsigned count, input int unsigned step_max);
		int unsigned sent;
		int unsigned stay;
		rate_band_t  band;
		logic        oxy_low;
		logic [3:0]  flags;
		sent = 0;
		while (sent < count) begin
			band    = rate_band_t'($urandom_range(0, 2));
			oxy_low = ($urandom_range(0, 2) == 0);
			stay    = $urandom_range(1, 24);
			for (int n = 0; n < stay && sent < count; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					// time may jump anywhere, including backwards
					now_ms = $urandom();
					measure(4'($urandom), RATE_W'($urandom), OXY_W'($urandom), now_ms);
				end else begin
					flags  = ($urandom_range(0, 7) == 0) ? 4'($urandom) : SENSOR_ALL_OK;
					now_ms = now_ms + $urandom_range(0, step_max);
					measure(flags, pick_rate(band), pick_oxygen(oxy_low), now_ms);
				end
				sent++;
			end
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = CFG_RATE_LOW;
		cfg_data             = '0;
		meas_ch.valid        = 1'b0;
		meas_ch.is_measuring = 1'b0;
		meas_ch.signal_ok    = 1'b0;
		meas_ch.rate_ok      = 1'b0;
		meas_ch.oxygen_ok    = 1'b0;
		meas_ch.heart_rate   = '0;
		meas_ch.oxygen_level = '0;
		meas_ch.time_ms      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset thresholds: hold times, limit edges, sensor gating
		measure(SENSOR_ALL_OK, 8'd0, 7'd0, 32'd0);
		measure(SENSOR_ALL_OK, 8'd49, 7'd89, 32'd4999);
		measure(SENSOR_ALL_OK, 8'd49, 7'd89, 32'd5000);
		measure(SENSOR_ALL_OK, 8'd255, 7'd100, 32'd5001);
		measure(SENSOR_ALL_OK, 8'd121, 7'd127, 32'd10001);
		measure(SENSOR_IDLE, 8'd255, 7'd0, 32'd10002);
		measure(SIGNAL_BAD, 8'd0, 7'd0, 32'd10003);
		measure(RATE_BAD, 8'd0, 7'd0, 32'd10004);
		measure(OXYGEN_BAD, 8'd0, 7'd0, 32'd10005);
		measure(SENSOR_ALL_OK, 8'd50, 7'd90, 32'd20000);
		measure(SENSOR_ALL_OK, 8'd120, 7'd90, 32'd30000);
		// timestamp wrap, then time running backwards
		measure(SENSOR_ALL_OK, 8'd0, 7'd0, 32'hFFFF_FF00);
		measure(SENSOR_ALL_OK, 8'd0, 7'd0, 32'h0000_1000);
		measure(SENSOR_ALL_OK, 8'd0, 7'd0, 32'h0000_1300);
		measure(SENSOR_ALL_OK, 8'd60, 7'd95, 32'h0000_1400);
		measure(SENSOR_ALL_OK, 8'd60, 7'd95, 32'h0000_1000);

		// zero hold times with limits at their extremes
		apply_setting(8'd255, 8'd0, 7'd127, '0, '0);
		measure(SENSOR_ALL_OK, 8'd0, 7'd127, 32'd100);
		measure(SENSOR_ALL_OK, 8'd255, 7'd126, 32'd100);
		measure(SENSOR_IDLE, 8'd128, 7'd0, 32'd101);
		measure(SENSOR_ALL_OK, 8'd128, 7'd0, 32'd101);

		// longest hold times: only one step back in time reaches them
		apply_setting(RATE_LOW_RST, RATE_HIGH_RST, OXY_LOW_RST, '1, '1);
		measure(SENSOR_ALL_OK, 8'd0, 7'd95, 32'd1000);
		measure(SENSOR_ALL_OK, 8'd0, 7'd95, 32'd999);
		measure(SENSOR_ALL_OK, 8'd70, 7'd95, 32'd998);
		measure(SENSOR_ALL_OK, 8'd70, 7'd95, 32'd997);

		// random traffic over a series of settings
		apply_setting(RATE_LOW_RST, RATE_HIGH_RST, OXY_LOW_RST, CONFIRM_RST, CLEAR_RST);
		run_traffic(250, 1500);
		apply_setting(8'd60, 8'd100, 7'd95, 32'd100, 32'd150);
		run_traffic(300, 40);
		apply_setting(8'd40, 8'd140, 7'd92, '0, '0);
		run_traffic(250, 10);
		apply_setting(8'd255, 8'd0, 7'd127, 32'd1, 32'd1);
		run_traffic(200, 3);
		apply_setting(8'd0, 8'd255, 7'd0, '1, '1);
		run_traffic(150, 1000);
		apply_setting(8'd55, 8'd110, 7'd93, 32'd20, 32'd300);
		run_traffic(300, 60);
		repeat (2) begin
			apply_setting(RATE_W'($urandom), RATE_W'($urandom), OXY_W'($urandom),
			              $urandom_range(0, 400), $urandom_range(0, 400));
			run_traffic(200, 100);
		end

		drain();
		repeat (4) @(negedge clk);
		$display("register settings applied: %0d, results checked: %0d", settings_used,
		         checked);
		$display("results with an alert raised: %0d, mismatches: %0d", raised, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
